@@ sv/v2dc_pkg.sv @@
// ============================================================================
// Valid-mode 2D convolution: shared package
// Types and fixed constants used by the interfaces and the convolution core.
// ============================================================================
package v2dc_pkg;

    localparam int ELEM_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int CFG_IMG_W = 11;
    localparam int CFG_KER_W = 4;

    localparam logic OP_KERNEL = 1'b0;
    localparam logic OP_IMAGE  = 1'b1;

    localparam logic [1:0] REG_IMAGE_ROWS  = 2'd0;
    localparam logic [1:0] REG_IMAGE_COLS  = 2'd1;
    localparam logic [1:0] REG_KERNEL_ROWS = 2'd2;
    localparam logic [1:0] REG_KERNEL_COLS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

@@ sv/v2dc_if.sv @@
// ============================================================================
// Valid-mode 2D convolution: stream interfaces
// Valid/ready channels for input elements and for convolution results.
// ============================================================================
interface v2dc_in_if import v2dc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output op, output element_value, input ready);
    modport sink   (input valid, input op, input element_value, output ready);
endinterface

interface v2dc_out_if import v2dc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] sum_value;
    logic                     last_output;
    logic                     size_error;

    modport source (output valid, output sum_value, output last_output,
                    output size_error, input ready);
    modport sink   (input valid, input sum_value, input last_output,
                    input size_error, output ready);
endinterface

@@ sv/v2dc_ram.sv @@
// ============================================================================
// Valid-mode 2D convolution: generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module v2dc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/valid_2d_convolution.sv @@
// ============================================================================
// Valid-mode 2D convolution
// Streams a signed image through a line store and convolves each full
// window with a 180-degree rotated kernel using one shared multiplier.
// ============================================================================
// Kernel elements (op=0) are loaded in row-major order, then image elements
// (op=1) stream in row-major order. Kernel elements and image elements that
// complete no window are taken back to back. An image element that completes
// a window holds off the input while the window is summed, since the single
// multiplier and the read ports of the kernel and line memories handle one
// product per cycle, and while the sum waits for the output register to be
// taken. A size error transaction also passes through the output register.
// Both memories power up undefined and need no clearing pass after reset.
module valid_2d_convolution import v2dc_pkg::*; #(
    parameter int MAX_IMAGE_COLS  = 1024,
    parameter int MAX_IMAGE_ROWS  = 1024,
    parameter int MAX_KERNEL_ROWS = 8,
    parameter int MAX_KERNEL_COLS = 8,
    parameter int DATA_WIDTH      = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    v2dc_in_if.sink            i_in,
    v2dc_out_if.source         o_out
);

    localparam int DW     = DATA_WIDTH;
    localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int LDEPTH = MAX_KERNEL_ROWS * MAX_IMAGE_COLS;
    localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int LA_W   = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int RW     = (MAX_IMAGE_ROWS > 1) ? $clog2(MAX_IMAGE_ROWS) : 1;
    localparam int CW     = (MAX_IMAGE_COLS > 1) ? $clog2(MAX_IMAGE_COLS) : 1;
    localparam int SL_W   = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
    localparam int KJ_W   = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
    localparam int SLX_W  = $clog2(2 * MAX_KERNEL_ROWS + 1);
    localparam int IRS_W  = ($clog2(MAX_IMAGE_ROWS + 1) > CFG_IMG_W) ?
                            $clog2(MAX_IMAGE_ROWS + 1) : CFG_IMG_W;
    localparam int ICS_W  = ($clog2(MAX_IMAGE_COLS + 1) > CFG_IMG_W) ?
                            $clog2(MAX_IMAGE_COLS + 1) : CFG_IMG_W;
    localparam int KRS_W  = ($clog2(MAX_KERNEL_ROWS + 1) > CFG_KER_W) ?
                            $clog2(MAX_KERNEL_ROWS + 1) : CFG_KER_W;
    localparam int KCS_W  = ($clog2(MAX_KERNEL_COLS + 1) > CFG_KER_W) ?
                            $clog2(MAX_KERNEL_COLS + 1) : CFG_KER_W;
    localparam int KK_W   = KRS_W + KCS_W;
    localparam int CMP_W  = ((IRS_W > ICS_W) ? IRS_W : ICS_W) + 1;

    // Configuration registers
    logic [CFG_IMG_W-1:0] r_img_rows, r_img_cols;
    logic [CFG_KER_W-1:0] r_ker_rows, r_ker_cols;

    // Stream position and kernel load state
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [SL_W-1:0] r_wslot, n_wslot;
    logic [KA_W-1:0] r_kidx, n_kidx;
    logic            r_err_rep, n_err_rep;

    // Sequencer
    t_state          r_state, n_state;
    logic [SL_W-1:0] r_i, n_i, r_slot, n_slot, r_kr_m1, n_kr_m1;
    logic [KJ_W-1:0] r_j, n_j, r_kc_m1, n_kc_m1;
    logic [CW-1:0]   r_lcol, n_lcol, r_c0, n_c0;
    logic [KA_W-1:0] r_kaddr, n_kaddr;
    logic            r_last, n_last, r_err, n_err;
    logic            r_p1, n_p1, r_p2, n_p2;
    logic [DW-1:0]   r_prod, n_prod, r_acc, n_acc;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [ELEM_W-1:0] r_out_sum, n_out_sum;
    logic              r_out_last, n_out_last, r_out_err, n_out_err;

    // Memory ports
    logic            k_we, l_we;
    logic [KA_W-1:0] k_waddr;
    logic [LA_W-1:0] l_waddr, l_raddr;
    logic [DW-1:0]   k_rdata, l_rdata;

    // Clamped sizes and derived values
    logic [IRS_W-1:0] rows_c;
    logic [ICS_W-1:0] cols_c;
    logic [KRS_W-1:0] kr_c;
    logic [KCS_W-1:0] kc_c;
    logic [KK_W-1:0]  kk_c, kidx_inc;
    logic [KA_W-1:0]  kidx_eff, kidx_next;
    logic [CMP_W-1:0] row_x, col_x, rows_x, cols_x, kr_x, kc_x;
    logic             last_col, last_row, size_bad, win_ok;
    logic [SLX_W-1:0] slot_t, slot0;
    logic             cfg_wr;

    always_comb begin
        rows_c = IRS_W'(r_img_rows);
        if (r_img_rows == '0) begin
            rows_c = IRS_W'(1);
        end else if (IRS_W'(r_img_rows) > IRS_W'(MAX_IMAGE_ROWS)) begin
            rows_c = IRS_W'(MAX_IMAGE_ROWS);
        end
        cols_c = ICS_W'(r_img_cols);
        if (r_img_cols == '0) begin
            cols_c = ICS_W'(1);
        end else if (ICS_W'(r_img_cols) > ICS_W'(MAX_IMAGE_COLS)) begin
            cols_c = ICS_W'(MAX_IMAGE_COLS);
        end
        kr_c = KRS_W'(r_ker_rows);
        if (r_ker_rows == '0) begin
            kr_c = KRS_W'(1);
        end else if (KRS_W'(r_ker_rows) > KRS_W'(MAX_KERNEL_ROWS)) begin
            kr_c = KRS_W'(MAX_KERNEL_ROWS);
        end
        kc_c = KCS_W'(r_ker_cols);
        if (r_ker_cols == '0) begin
            kc_c = KCS_W'(1);
        end else if (KCS_W'(r_ker_cols) > KCS_W'(MAX_KERNEL_COLS)) begin
            kc_c = KCS_W'(MAX_KERNEL_COLS);
        end
    end

    assign kk_c      = KK_W'(kr_c) * KK_W'(kc_c);
    assign kidx_eff  = (KK_W'(r_kidx) >= kk_c) ? '0 : r_kidx;
    assign kidx_inc  = KK_W'(kidx_eff) + KK_W'(1);
    assign kidx_next = (kidx_inc >= kk_c) ? '0 : KA_W'(kidx_inc);

    assign row_x    = CMP_W'(r_row);
    assign col_x    = CMP_W'(r_col);
    assign rows_x   = CMP_W'(rows_c);
    assign cols_x   = CMP_W'(cols_c);
    assign kr_x     = CMP_W'(kr_c);
    assign kc_x     = CMP_W'(kc_c);
    assign last_col = col_x >= cols_x - CMP_W'(1);
    assign last_row = row_x >= rows_x - CMP_W'(1);
    assign size_bad = (kr_x > rows_x) || (kc_x > cols_x);
    assign win_ok   = (row_x >= kr_x - CMP_W'(1)) && (col_x >= kc_x - CMP_W'(1)) &&
                      (col_x < cols_x);

    assign slot_t = SLX_W'(r_wslot) + SLX_W'(MAX_KERNEL_ROWS) - SLX_W'(kr_c - KRS_W'(1));
    assign slot0  = (slot_t >= SLX_W'(MAX_KERNEL_ROWS)) ?
                    slot_t - SLX_W'(MAX_KERNEL_ROWS) : slot_t;

    assign l_waddr = LA_W'(LA_W'(r_wslot) * LA_W'(MAX_IMAGE_COLS) + LA_W'(r_col));
    assign l_raddr = LA_W'(LA_W'(r_slot) * LA_W'(MAX_IMAGE_COLS) + LA_W'(r_lcol));

    v2dc_ram #(
        .WIDTH (DW),
        .DEPTH (KDEPTH)
    ) u_kernel_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (i_in.element_value[DW-1:0]),
        .i_raddr (r_kaddr),
        .o_rdata (k_rdata)
    );

    v2dc_ram #(
        .WIDTH (DW),
        .DEPTH (LDEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (i_in.element_value[DW-1:0]),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // Configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_IMAGE_ROWS:  prdata = PDATA_W'(r_img_rows);
            REG_IMAGE_COLS:  prdata = PDATA_W'(r_img_cols);
            REG_KERNEL_ROWS: prdata = PDATA_W'(r_ker_rows);
            REG_KERNEL_COLS: prdata = PDATA_W'(r_ker_cols);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_rows <= CFG_IMG_W'(1);
            r_img_cols <= CFG_IMG_W'(1);
            r_ker_rows <= CFG_KER_W'(1);
            r_ker_cols <= CFG_KER_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[PADDR_W-1:2])
                REG_IMAGE_ROWS:  r_img_rows <= pwdata[CFG_IMG_W-1:0];
                REG_IMAGE_COLS:  r_img_cols <= pwdata[CFG_IMG_W-1:0];
                REG_KERNEL_ROWS: r_ker_rows <= pwdata[CFG_KER_W-1:0];
                REG_KERNEL_COLS: r_ker_cols <= pwdata[CFG_KER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_wslot     = r_wslot;
        n_kidx      = r_kidx;
        n_err_rep   = r_err_rep;
        n_i         = r_i;
        n_j         = r_j;
        n_slot      = r_slot;
        n_lcol      = r_lcol;
        n_c0        = r_c0;
        n_kaddr     = r_kaddr;
        n_kr_m1     = r_kr_m1;
        n_kc_m1     = r_kc_m1;
        n_last      = r_last;
        n_err       = r_err;
        n_p1        = (r_state == ST_RUN);
        n_p2        = r_p1;
        n_prod      = k_rdata * l_rdata;
        n_acc       = r_p2 ? r_acc + r_prod : r_acc;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_sum   = r_out_sum;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        k_we        = 1'b0;
        l_we        = 1'b0;
        k_waddr     = kidx_eff;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.op == OP_KERNEL) begin
                        k_we   = 1'b1;
                        n_kidx = kidx_next;
                    end else begin
                        l_we = 1'b1;
                        if (size_bad) begin
                            if (!r_err_rep) begin
                                n_err_rep = 1'b1;
                                n_err     = 1'b1;
                                n_last    = 1'b0;
                                n_acc     = '0;
                                n_state   = ST_DONE;
                            end
                        end else if (!r_err_rep && win_ok) begin
                            n_i     = '0;
                            n_j     = '0;
                            n_slot  = SL_W'(slot0);
                            n_c0    = CW'(col_x - (kc_x - CMP_W'(1)));
                            n_lcol  = CW'(col_x - (kc_x - CMP_W'(1)));
                            n_kaddr = KA_W'(kk_c - KK_W'(1));
                            n_kr_m1 = SL_W'(kr_c - KRS_W'(1));
                            n_kc_m1 = KJ_W'(kc_c - KCS_W'(1));
                            n_last  = last_col && last_row;
                            n_err   = 1'b0;
                            n_acc   = '0;
                            n_state = ST_RUN;
                        end
                        if (last_col) begin
                            n_col = '0;
                            if (last_row) begin
                                n_row     = '0;
                                n_wslot   = '0;
                                n_err_rep = 1'b0;
                            end else begin
                                n_row   = r_row + RW'(1);
                                n_wslot = (r_wslot == SL_W'(MAX_KERNEL_ROWS - 1)) ?
                                          '0 : r_wslot + SL_W'(1);
                            end
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                end
            end
            ST_RUN: begin
                n_kaddr = r_kaddr - KA_W'(1);
                if (r_j == r_kc_m1) begin
                    n_j    = '0;
                    n_lcol = r_c0;
                    n_slot = (r_slot == SL_W'(MAX_KERNEL_ROWS - 1)) ?
                             '0 : r_slot + SL_W'(1);
                    if (r_i == r_kr_m1) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i = r_i + SL_W'(1);
                    end
                end else begin
                    n_j    = r_j + KJ_W'(1);
                    n_lcol = r_lcol + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = ELEM_W'(signed'(r_acc));
                    n_out_last  = r_last;
                    n_out_err   = r_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_wslot     <= '0;
            r_kidx      <= '0;
            r_err_rep   <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_wslot     <= n_wslot;
            r_kidx      <= n_kidx;
            r_err_rep   <= n_err_rep;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_slot     <= n_slot;
        r_lcol     <= n_lcol;
        r_c0       <= n_c0;
        r_kaddr    <= n_kaddr;
        r_kr_m1    <= n_kr_m1;
        r_kc_m1    <= n_kc_m1;
        r_last     <= n_last;
        r_err      <= n_err;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_out_sum  <= n_out_sum;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.sum_value   = r_out_sum;
    assign o_out.last_output = r_out_last;
    assign o_out.size_error  = r_out_err;

    // The product pipeline is only ever filled by the issue state.
    a_pipe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |-> $past(r_state) == ST_RUN)
        else $error("product pipeline advanced without a read issue");

    // No product may still be in flight once the sequencer is idle again.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1 && !r_p2))
        else $error("idle with products still in flight");

    // Window counters stay inside the latched kernel size.
    a_run_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_i <= r_kr_m1 && r_j <= r_kc_m1))
        else $error("window counter out of range");

    // A size error transaction carries no sum and no end-of-image mark.
    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.size_error) |-> (o_out.sum_value == '0 && !o_out.last_output))
        else $error("size error transaction with a payload");

endmodule

@@ tb/valid_2d_convolution_tb.sv @@
// ============================================================================
// Valid-mode 2D convolution: self-checking testbench
// Loads kernels and streams signed images through the block under a range of
// register settings, predicts every convolution sum and size error in a local
// model of the line store, and compares each result transaction field by
// field while both sides of the stream pause at random.
// ============================================================================
`timescale 1ns / 100ps

module valid_2d_convolution_tb import v2dc_pkg::*; ();

    localparam int MAX_IMAGE_COLS  = 1024;
    localparam int MAX_IMAGE_ROWS  = 1024;
    localparam int MAX_KERNEL_ROWS = 8;
    localparam int MAX_KERNEL_COLS = 8;
    localparam int KERNEL_DEPTH    = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int IMG_FIELD_MAX   = (1 << CFG_IMG_W) - 1;
    localparam int KER_FIELD_MAX   = (1 << CFG_KER_W) - 1;
    localparam int ITEM_TARGET     = 1800;
    localparam int SETTLE_CYCLES   = 80;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 50;

    typedef struct packed {
        logic              op;
        logic [ELEM_W-1:0] element_value;
    } t_element;

    typedef struct packed {
        logic [ELEM_W-1:0] sum_value;
        logic              last_output;
        logic              size_error;
    } t_conv_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    v2dc_in_if  elem_if ();
    v2dc_out_if conv_if ();

    valid_2d_convolution #(
        .MAX_IMAGE_COLS  (MAX_IMAGE_COLS),
        .MAX_IMAGE_ROWS  (MAX_IMAGE_ROWS),
        .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
        .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
        .DATA_WIDTH      (ELEM_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (elem_if),
        .o_out   (conv_if)
    );

    always #2 i_clk = ~i_clk;

    logic [CFG_IMG_W-1:0] geom_image_rows = CFG_IMG_W'(1);
    logic [CFG_IMG_W-1:0] geom_image_cols = CFG_IMG_W'(1);
    logic [CFG_KER_W-1:0] geom_kernel_rows = CFG_KER_W'(1);
    logic [CFG_KER_W-1:0] geom_kernel_cols = CFG_KER_W'(1);
    logic [ELEM_W-1:0] kernel_mem [KERNEL_DEPTH];
    bit                kernel_written [KERNEL_DEPTH];
    logic [ELEM_W-1:0] window_rows [MAX_KERNEL_ROWS][MAX_IMAGE_COLS];
    int unsigned       kernel_ptr;
    int unsigned       row_pos;
    int unsigned       col_pos;
    bit                error_pending;

    t_element     element_feed [$];
    t_conv_result pending_sums [$];
    t_element     next_element;
    t_conv_result expected_sum;

    int unsigned n_queued;
    int unsigned n_elements;
    int unsigned n_results;
    int unsigned n_size_errors;
    int unsigned n_settings;
    int unsigned mismatch_count;
    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned recv_hold;
    int unsigned stall_cycles;
    bit          drv_burst;
    bit          mon_burst;

    function automatic int unsigned clamp_dim(int unsigned raw, int unsigned hi);
        if (raw < 1) return 1;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic void convolve_element(logic op, logic [ELEM_W-1:0] value);
        int unsigned rows, cols, kr, kc, r0, c0, i, j;
        logic [ELEM_W-1:0] acc;
        bit last_col, last_row;
        t_conv_result res;
        rows = clamp_dim(geom_image_rows, MAX_IMAGE_ROWS);
        cols = clamp_dim(geom_image_cols, MAX_IMAGE_COLS);
        kr = clamp_dim(geom_kernel_rows, MAX_KERNEL_ROWS);
        kc = clamp_dim(geom_kernel_cols, MAX_KERNEL_COLS);
        if (op == OP_KERNEL) begin
            if (kernel_ptr >= kr * kc) kernel_ptr = 0;
            kernel_mem[kernel_ptr] = value;
            kernel_written[kernel_ptr] = 1'b1;
            kernel_ptr++;
            if (kernel_ptr >= kr * kc) kernel_ptr = 0;
            return;
        end
        last_col = col_pos >= cols - 1;
        last_row = row_pos >= rows - 1;
        window_rows[row_pos % MAX_KERNEL_ROWS][col_pos] = value;
        if (kr > rows || kc > cols) begin
            if (!error_pending) begin
                error_pending = 1'b1;
                res.sum_value = '0;
                res.last_output = 1'b0;
                res.size_error = 1'b1;
                pending_sums.push_back(res);
            end
        end else if (!error_pending && row_pos >= kr - 1 && col_pos >= kc - 1 &&
                     col_pos < cols) begin
            r0 = row_pos - (kr - 1);
            c0 = col_pos - (kc - 1);
            acc = '0;
            for (i = 0; i < kr; i++) begin
                for (j = 0; j < kc; j++) begin
                    acc += window_rows[(r0 + i) % MAX_KERNEL_ROWS][c0 + j] *
                           kernel_mem[(kr - 1 - i) * kc + (kc - 1 - j)];
                end
            end
            res.sum_value = acc;
            res.last_output = last_col && last_row;
            res.size_error = 1'b0;
            pending_sums.push_back(res);
        end
        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos = 0;
                error_pending = 1'b0;
            end else begin
                row_pos = (row_pos + 1) % 1024;
            end
        end else begin
            col_pos = (col_pos + 1) % 1024;
        end
    endfunction

    function automatic bit kernel_complete(int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if (!kernel_written[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic int unsigned raw_size(int unsigned eff, int unsigned top,
                                             int unsigned field_max);
        if (eff == 1 && $urandom_range(0, 3) == 0) return 0;
        if (eff == top && $urandom_range(0, 1) == 0) return $urandom_range(top, field_max);
        return eff;
    endfunction

    task automatic flag_mismatch(string field, logic [ELEM_W-1:0] got,
                                 logic [ELEM_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("Result %0d: %s is %h, expected %h", n_results, field, got, want);
        end
    endtask

    task automatic push_element(logic op, logic [ELEM_W-1:0] value);
        t_element e;
        e.op = op;
        e.element_value = value;
        element_feed.push_back(e);
        n_queued++;
    endtask

    task automatic queue_kernel(int unsigned count);
        repeat (count) push_element(OP_KERNEL, random_element());
    endtask

    task automatic queue_image(int unsigned count, int unsigned noise_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < noise_pct) push_element(OP_KERNEL, random_element());
            push_element(OP_IMAGE, random_element());
        end
    endtask

    task automatic wait_idle();
        while (n_elements != n_queued || pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_ROWS:  geom_image_rows = value[CFG_IMG_W-1:0];
            REG_IMAGE_COLS:  geom_image_cols = value[CFG_IMG_W-1:0];
            REG_KERNEL_ROWS: geom_kernel_rows = value[CFG_KER_W-1:0];
            REG_KERNEL_COLS: geom_kernel_cols = value[CFG_KER_W-1:0];
        endcase
    endtask

    task automatic set_geometry(int unsigned rows, int unsigned cols,
                                int unsigned kr, int unsigned kc);
        wait_idle();
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_IMAGE_COLS, cols);
        write_reg(REG_KERNEL_ROWS, kr);
        write_reg(REG_KERNEL_COLS, kc);
        n_settings++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_if.valid <= 1'b0;
            send_wait <= draw_wait(1'b0);
        end else begin
            if (elem_if.valid && elem_if.ready) begin
                convolve_element(elem_if.op, elem_if.element_value);
                n_elements++;
            end
            if (!elem_if.valid || elem_if.ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    elem_if.valid <= 1'b0;
                end else if (element_feed.size() != 0) begin
                    next_element = element_feed.pop_front();
                    elem_if.op <= next_element.op;
                    elem_if.element_value <= next_element.element_value;
                    elem_if.valid <= 1'b1;
                    send_wait <= draw_wait(drv_burst);
                end else begin
                    elem_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            conv_if.ready <= 1'b0;
            recv_wait <= 0;
        end else if (conv_if.valid && conv_if.ready) begin
            n_results++;
            if (pending_sums.size() == 0) begin
                flag_mismatch("transaction with nothing expected, sum_value",
                              conv_if.sum_value, '0);
            end else begin
                expected_sum = pending_sums.pop_front();
                if (expected_sum.size_error) n_size_errors++;
                if (conv_if.sum_value !== expected_sum.sum_value)
                    flag_mismatch("sum_value", conv_if.sum_value, expected_sum.sum_value);
                if (conv_if.last_output !== expected_sum.last_output)
                    flag_mismatch("last_output", conv_if.last_output,
                                  expected_sum.last_output);
                if (conv_if.size_error !== expected_sum.size_error)
                    flag_mismatch("size_error", conv_if.size_error,
                                  expected_sum.size_error);
            end
            recv_hold = (n_results % 500 == 100) ? LONG_HOLD : draw_wait(mon_burst);
            recv_wait <= recv_hold;
            conv_if.ready <= (recv_hold == 0);
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            conv_if.ready <= (recv_wait == 1);
        end else begin
            conv_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (elem_if.valid && elem_if.ready) ||
            (conv_if.valid && conv_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned img_r, img_c, ker_r, ker_c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One by one image and kernel at reset sizes: extreme products.
        push_element(OP_KERNEL, 32'h8000_0000);
        push_element(OP_IMAGE, 32'h7FFF_FFFF);
        push_element(OP_IMAGE, 32'h8000_0000);
        push_element(OP_IMAGE, 32'hFFFF_FFFF);
        push_element(OP_IMAGE, 32'h0000_0000);
        push_element(OP_KERNEL, 32'h7FFF_FFFF);
        push_element(OP_IMAGE, 32'h7FFF_FFFF);

        // Zero and oversized register values saturate; the kernel is too tall.
        set_geometry(0, 0, KER_FIELD_MAX, 0);
        push_element(OP_IMAGE, 32'h1234_5678);
        push_element(OP_IMAGE, 32'hEDCB_A987);

        // Small image with a kernel element replaced in the middle of it.
        set_geometry(2, 3, 2, 2);
        push_element(OP_KERNEL, 32'h7FFF_FFFF);
        push_element(OP_KERNEL, 32'h8000_0000);
        push_element(OP_KERNEL, 32'hFFFF_FFFF);
        push_element(OP_KERNEL, 32'h0000_0001);
        push_element(OP_IMAGE, 32'h8000_0000);
        push_element(OP_IMAGE, 32'h7FFF_FFFF);
        push_element(OP_IMAGE, 32'hFFFF_FFFF);
        push_element(OP_KERNEL, 32'h0000_0002);
        push_element(OP_IMAGE, 32'h0000_0000);
        push_element(OP_IMAGE, 32'h7FFF_FFFF);
        push_element(OP_IMAGE, 32'h8000_0000);

        // Kernel wider than the image, two images in a row.
        set_geometry(2, 1, 1, 2);
        repeat (4) push_element(OP_IMAGE, random_element());

        // Full-width row, with a long receiver hold somewhere inside it.
        drv_burst = 1'b1;
        mon_burst = 1'b0;
        set_geometry(1, IMG_FIELD_MAX, 1, KER_FIELD_MAX);
        queue_kernel(MAX_KERNEL_COLS);
        queue_image(MAX_IMAGE_COLS, 2);

        // Tall image cut short by shrinking the row count mid-image.
        drv_burst = 1'b0;
        set_geometry(IMG_FIELD_MAX, 1, MAX_KERNEL_ROWS, 1);
        queue_kernel(MAX_KERNEL_ROWS);
        queue_image(20, 0);
        wait_idle();
        write_reg(REG_IMAGE_ROWS, 1);
        queue_image(1, 0);

        // Column count shrunk below the current column mid-image.
        set_geometry(4, 10, 2, 2);
        queue_kernel(4);
        queue_image(15, 0);
        wait_idle();
        write_reg(REG_IMAGE_COLS, 3);
        queue_image(7, 0);

        while (n_queued < ITEM_TARGET) begin
            img_r = $urandom_range(1, 10);
            img_c = $urandom_range(1, 12);
            if ($urandom_range(0, 99) < 15) begin
                img_r = $urandom_range(1, 7);
                ker_r = $urandom_range(img_r + 1, MAX_KERNEL_ROWS);
                ker_c = $urandom_range(1, MAX_KERNEL_COLS);
            end else begin
                ker_r = $urandom_range(1, (img_r < MAX_KERNEL_ROWS) ? img_r : MAX_KERNEL_ROWS);
                ker_c = $urandom_range(1, (img_c < MAX_KERNEL_COLS) ? img_c : MAX_KERNEL_COLS);
            end
            set_geometry(raw_size(img_r, MAX_IMAGE_ROWS, IMG_FIELD_MAX),
                         raw_size(img_c, MAX_IMAGE_COLS, IMG_FIELD_MAX),
                         raw_size(ker_r, MAX_KERNEL_ROWS, KER_FIELD_MAX),
                         raw_size(ker_c, MAX_KERNEL_COLS, KER_FIELD_MAX));
            drv_burst = ($urandom_range(0, 3) == 0);
            mon_burst = ($urandom_range(0, 3) == 0);
            if (!kernel_complete(ker_r * ker_c) || $urandom_range(0, 3) != 0) begin
                queue_kernel(ker_r * ker_c);
            end else if ($urandom_range(0, 1) == 0) begin
                queue_kernel($urandom_range(1, ker_r * ker_c));
            end
            queue_image(img_r * img_c, 4);
        end

        wait_idle();
        $display("Streamed %0d elements under %0d register settings.", n_elements, n_settings);
        $display("Checked %0d result transactions, %0d of them size errors.",
                 n_results, n_size_errors);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/v2dc_pkg.sv
sv/v2dc_if.sv
sv/v2dc_ram.sv
sv/valid_2d_convolution.sv
tb/valid_2d_convolution_tb.sv
